[src/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes for the max-tracking stack: request and response
// payloads, operation and status codes, controller command and status.
// ----------------------------------------------------------------------------
package mts_pkg;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

  // Request payload
  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
  } req_t;

  // Response payload
  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] current_max;
    logic               is_empty;
    logic        [1:0]  status;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture the accepted request
    logic exec;  // apply the operation to the stacks
    logic fill;  // reload the cached tops from memory
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_needed;  // valid during exec: a cached top must be reloaded
  } dp_stat_t;

endpackage

[src/mts_datapath.sv]
// ----------------------------------------------------------------------------
// mts_datapath
// Value stack and (maximum, repeat count) side stack. Each stack keeps its
// top entry in registers and the entries below it in a memory.
// ----------------------------------------------------------------------------
module mts_datapath #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  mts_pkg::dp_cmd_t cmd,
  input  mts_pkg::req_t    req,
  output mts_pkg::dp_stat_t stat,
  output mts_pkg::rsp_t    rsp
);
  import mts_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = DATA_WIDTH;

  // Captured request
  logic                 op_q;
  logic [DW-1:0]        val_q;
  logic [DW-1:0]        val_in;

  // Cached tops and counts
  logic [DW-1:0]        vtop;
  logic [CW-1:0]        vcnt;
  logic [DW-1:0]        mtop;
  logic [CW-1:0]        mrep;
  logic [CW-1:0]        mcnt;

  // Result registers
  logic [DW-1:0]        popped;
  logic [1:0]           status_q;

  // Refill bookkeeping and registered read data
  logic                 fill_v;
  logic                 fill_m;
  logic [DW-1:0]        vrd;
  logic [DW+CW-1:0]     mrd;

  // Memories below the cached tops
  logic [DW-1:0]        vmem [DEPTH];
  logic [DW+CW-1:0]     mmem [DEPTH];

  logic [CW-1:0]        vcnt_m1;
  logic [CW-1:0]        vcnt_m2;
  logic [CW-1:0]        mcnt_m1;
  logic [CW-1:0]        mcnt_m2;

  logic                 is_push;
  logic                 full;
  logic                 empty;
  logic                 new_max;
  logic                 eq_max;
  logic                 pop_hits_max;
  logic                 drop_pair;
  logic                 need_v;
  logic                 need_m;
  logic [31:0]          popped_field;
  logic [31:0]          max_field;

  // Fit the 32-bit request field to the data width, and data back to 32 bits
  generate
    if (DW > 32) begin : g_wide
      assign val_in       = {{(DW-32){1'b0}}, req.value};
      assign popped_field = popped[31:0];
      assign max_field    = mtop[31:0];
    end else if (DW == 32) begin : g_exact
      assign val_in       = req.value;
      assign popped_field = popped;
      assign max_field    = mtop;
    end else begin : g_narrow
      assign val_in       = req.value[DW-1:0];
      assign popped_field = {{(32-DW){popped[DW-1]}}, popped};
      assign max_field    = {{(32-DW){mtop[DW-1]}}, mtop};
    end
  endgenerate

  // Decode the operation against the current state
  always_comb begin
    vcnt_m1      = vcnt - CW'(1);
    vcnt_m2      = vcnt - CW'(2);
    mcnt_m1      = mcnt - CW'(1);
    mcnt_m2      = mcnt - CW'(2);
    is_push      = (op_q == OP_PUSH);
    full         = (vcnt == CW'(DEPTH));
    empty        = (vcnt == '0);
    new_max      = (mcnt == '0) || ($signed(val_q) > $signed(mtop));
    eq_max       = (mtop == val_q);
    pop_hits_max = (mcnt != '0) && (mtop == vtop);
    drop_pair    = pop_hits_max && (mrep <= CW'(1));
    need_v       = !is_push && (vcnt > CW'(1));
    need_m       = !is_push && !empty && drop_pair && (mcnt > CW'(1));
  end

  assign stat.fill_needed = need_v || need_m;

  // Counts and refill flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt   <= '0;
      mcnt   <= '0;
      fill_v <= 1'b0;
      fill_m <= 1'b0;
    end else if (cmd.exec) begin
      if (is_push) begin
        if (!full) begin
          vcnt <= vcnt + CW'(1);
          if (new_max) begin
            mcnt <= mcnt + CW'(1);
          end
        end
      end else if (!empty) begin
        vcnt   <= vcnt_m1;
        fill_v <= need_v;
        fill_m <= need_m;
        if (drop_pair) begin
          mcnt <= mcnt_m1;
        end
      end
    end else if (cmd.fill) begin
      fill_v <= 1'b0;
      fill_m <= 1'b0;
    end
  end

  // Request capture, cached tops and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= req.op;
      val_q <= val_in;
    end
    if (cmd.exec) begin
      if (is_push) begin
        popped <= '0;
        if (full) begin
          status_q <= ST_PUSH_FULL;
        end else begin
          status_q <= ST_OK;
          vtop     <= val_q;
          if (new_max) begin
            mtop <= val_q;
            mrep <= CW'(1);
          end else if (eq_max) begin
            mrep <= mrep + CW'(1);
          end
        end
      end else if (empty) begin
        popped   <= '0;
        status_q <= ST_POP_EMPTY;
      end else begin
        status_q <= ST_OK;
        popped   <= vtop;
        if (pop_hits_max && !drop_pair) begin
          mrep <= mrep - CW'(1);
        end
      end
    end
    if (cmd.fill) begin
      if (fill_v) begin
        vtop <= vrd;
      end
      if (fill_m) begin
        mtop <= mrd[DW+CW-1:CW];
        mrep <= mrd[CW-1:0];
      end
    end
  end

  // Spill old tops on push, fetch the entry below on pop
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (is_push && !full) begin
        if (!empty) begin
          vmem[vcnt_m1[AW-1:0]] <= vtop;
        end
        if (new_max && (mcnt != '0)) begin
          mmem[mcnt_m1[AW-1:0]] <= {mtop, mrep};
        end
      end
      if (!is_push) begin
        vrd <= vmem[vcnt_m2[AW-1:0]];
        mrd <= mmem[mcnt_m2[AW-1:0]];
      end
    end
  end

  // Response fields
  assign rsp.popped_value = popped_field;
  assign rsp.current_max  = ((vcnt != '0) && (mcnt != '0)) ? max_field : '0;
  assign rsp.is_empty     = (vcnt == '0);
  assign rsp.status       = status_q;

  // Side stack never outgrows the value stack
  a_side_le_value: assert property (@(posedge clk) disable iff (rst)
    mcnt <= vcnt)
    else $error("side stack deeper than value stack");

  // A held value implies a tracked maximum
  a_max_when_held: assert property (@(posedge clk) disable iff (rst)
    (vcnt != '0) |-> (mcnt != '0))
    else $error("values held without a tracked maximum");

  // Tracked pair has a nonzero repeat count outside refill cycles
  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    (mcnt != '0) && !cmd.fill |-> (mrep != '0))
    else $error("tracked maximum with zero repeat count");

  // Rejected push leaves the stack full
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && is_push && full |=> (vcnt == CW'(DEPTH)) && (status_q == ST_PUSH_FULL))
    else $error("push on full stack changed state");

endmodule

[src/mts_ctrl.sv]
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer for one request at a time: accept, execute, optional refill of
// the cached tops, then hold the response until it is taken.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  mts_pkg::dp_stat_t stat,
  output mts_pkg::dp_cmd_t  cmd
);
  import mts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_DONE
  } state_t;

  state_t state;

  // Commands to the datapath
  always_comb begin
    cmd.load = req_valid && req_ready;
    cmd.exec = (state == S_EXEC);
    cmd.fill = (state == S_FILL);
  end

  // Advance the sequence; ready and valid are registered
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state     <= S_EXEC;
            req_ready <= 1'b0;
          end
        end
        S_EXEC: begin
          if (stat.fill_needed) begin
            state <= S_FILL;
          end else begin
            state     <= S_DONE;
            rsp_valid <= 1'b1;
          end
        end
        S_FILL: begin
          state     <= S_DONE;
          rsp_valid <= 1'b1;
        end
        S_DONE: begin
          if (rsp_ready) begin
            state     <= S_IDLE;
            rsp_valid <= 1'b0;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          req_ready <= 1'b1;
          rsp_valid <= 1'b0;
        end
      endcase
    end
  end

  // Never take a request while a response is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request accepted with response pending");

  // Response is offered only once the work is finished
  a_valid_in_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (state == S_DONE))
    else $error("response offered before completion");

  // Requests are taken only while idle
  a_ready_in_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> (state == S_IDLE))
    else $error("request ready outside idle");

endmodule

[src/max_tracking_stack_core.sv]
// Flow: the single sequencer runs accept, execute, refill and response in turn;
//   the refill step runs only when a pop must reload a cached top from the
//   stack memories. A new request is not taken until the response is taken,
//   so a low rsp_ready holds off the next request.
// Reset: synchronous, active high; both stacks empty, stack memories not cleared.
// ----------------------------------------------------------------------------
// max_tracking_stack_core
// Bounded signed stack that reports its current maximum with every response.
// ----------------------------------------------------------------------------
module max_tracking_stack_core #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mts_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mts_pkg::rsp_t rsp_data
);
  import mts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Stacks and result
  mts_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req_data),
    .stat (stat),
    .rsp  (rsp_data)
  );

endmodule
